// ===== hw/rtl/wssm_pkg.sv =====
// ----------------------------------------------------------------------------
// wssm_pkg
// Shared types and fixed constants of the weight-stationary systolic array.
// ----------------------------------------------------------------------------
package wssm_pkg;

    localparam int ELEM_BITS      = 8;
    localparam int ELEMS_PER_WORD = 4;
    localparam int WORD_BITS      = ELEM_BITS * ELEMS_PER_WORD;
    localparam int INDEX_BITS     = 6;
    localparam int KIND_BITS      = 2;
    localparam int IN_DATA_BITS   = 40;
    localparam int OUT_DATA_BITS  = 40;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_LOAD_WEIGHTS = 2'd0,
        KIND_STREAM       = 2'd1,
        KIND_STORE        = 2'd2,
        KIND_NOP          = 2'd3
    } t_kind;

    typedef logic [ELEM_BITS-1:0] t_elem;

    typedef struct packed {
        logic  advance;
        logic  w_we;
        t_elem w_data;
    } t_pe_ctrl;

endpackage

// ===== hw/rtl/weight_stationary_systolic_matmul_top.sv =====
// ----------------------------------------------------------------------------
// weight_stationary_systolic_matmul_top
// ARRAY_DIM x ARRAY_DIM weight-stationary systolic array with input skew and
// output de-skew buffers, fed and drained by stream beats.
// ----------------------------------------------------------------------------
// One input beat gives one result beat. The block takes a beat every clock
// while the result register is empty or being drained, so one item per cycle;
// the result register holds one beat. The cycle covers the cell multiply-add
// of the bottom-right element and the result byte select. kind 0 loads four
// weights at a flat index, kind 1 writes activations, advances the array one
// step and reads, kind 2 writes activations and reads without advancing. No
// clearing pass: all state is ready out of reset.
// ----------------------------------------------------------------------------
module weight_stationary_systolic_matmul_top #(
    parameter int ARRAY_DIM = 8,
    parameter int ACC_BITS  = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [5:0] index, [37:6] bus_word, [39:38] zero
    input  logic [wssm_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    // [1:0] kind
    input  logic [wssm_pkg::KIND_BITS-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [31:0] result_word, [32] nonzero_tile, [39:33] zero
    output logic [wssm_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata
);
    import wssm_pkg::*;

    localparam int MAX_K = 70 / ARRAY_DIM + 1;

    function automatic logic mod_hit(input int v, input int r);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k <= MAX_K; k++) begin
            hit = hit | (v == r + k * ARRAY_DIM);
        end
        return hit;
    endfunction

    t_kind                 kind;
    logic [INDEX_BITS-1:0] idx;
    logic [WORD_BITS-1:0]  word;
    logic                  accept;
    logic                  advance;
    logic                  store;
    logic                  load_w;
    t_elem                 elem [ELEMS_PER_WORD];

    logic                  row_we   [ARRAY_DIM];
    t_elem                 row_data [ARRAY_DIM];
    t_elem                 row_tap  [ARRAY_DIM];

    t_elem                 act_link [ARRAY_DIM][ARRAY_DIM];
    logic [ACC_BITS-1:0]   psum     [ARRAY_DIM][ARRAY_DIM];
    logic [ACC_BITS-1:0]   psum_nx  [ARRAY_DIM][ARRAY_DIM];
    t_elem                 tap_next [ARRAY_DIM];

    logic                  r_flag;
    logic                  n_flag;
    logic                  r_out_valid;
    logic [WORD_BITS-1:0]  r_out_word;
    logic                  r_out_flag;
    logic [WORD_BITS-1:0]  n_word;
    logic [WORD_BITS-1:0]  read_word;

    assign kind    = t_kind'(s_axis_tuser);
    assign idx     = s_axis_tdata[INDEX_BITS-1:0];
    assign word    = s_axis_tdata[INDEX_BITS +: WORD_BITS];
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign advance = accept && (kind == KIND_STREAM);
    assign store   = accept && (kind == KIND_STREAM || kind == KIND_STORE);
    assign load_w  = accept && (kind == KIND_LOAD_WEIGHTS);

    always_comb begin
        for (int i = 0; i < ELEMS_PER_WORD; i++) begin
            elem[i] = word[WORD_BITS-1-ELEM_BITS*i -: ELEM_BITS];
        end
        for (int r = 0; r < ARRAY_DIM; r++) begin
            row_we[r]   = 1'b0;
            row_data[r] = '0;
            for (int i = 0; i < ELEMS_PER_WORD; i++) begin
                if (mod_hit(int'(idx) + i, r)) begin
                    row_we[r]   = store;
                    row_data[r] = row_data[r] | elem[i];
                end
            end
        end
    end

    // Input skew rows, processing element grid
    for (genvar r = 0; r < ARRAY_DIM; r++) begin : g_row
        wssm_skew_row #(
            .ARRAY_DIM (ARRAY_DIM),
            .WR_COL    (ARRAY_DIM - 1 - r)
        ) u_skew (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_we      (row_we[r]),
            .i_data    (row_data[r]),
            .i_advance (advance),
            .o_tap     (row_tap[r])
        );

        for (genvar c = 0; c < ARRAY_DIM; c++) begin : g_col
            t_pe_ctrl            ctrl;
            t_elem               act_in;
            logic [ACC_BITS-1:0] psum_in;
            logic                w_hit;

            always_comb begin
                w_hit = 1'b0;
                for (int i = 0; i < ELEMS_PER_WORD; i++) begin
                    w_hit = w_hit | (int'(idx) + i == r * ARRAY_DIM + c);
                end
                ctrl.advance = advance;
                ctrl.w_we    = load_w && w_hit;
                ctrl.w_data  = '0;
                for (int i = 0; i < ELEMS_PER_WORD; i++) begin
                    if (int'(idx) + i == r * ARRAY_DIM + c) begin
                        ctrl.w_data = elem[i];
                    end
                end
            end

            if (c == 0) begin : g_act_edge
                assign act_in = row_tap[r];
            end else begin : g_act_chain
                assign act_in = act_link[r][c-1];
            end

            if (r == 0) begin : g_ps_edge
                assign psum_in = '0;
            end else begin : g_ps_chain
                assign psum_in = psum[r-1][c];
            end

            wssm_pe #(
                .ACC_BITS (ACC_BITS)
            ) u_pe (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (ctrl),
                .i_act       (act_in),
                .i_psum      (psum_in),
                .o_act       (act_link[r][c]),
                .o_psum      (psum[r][c]),
                .o_psum_next (psum_nx[r][c])
            );
        end
    end

    // Output de-skew: column c is read after ARRAY_DIM-1-c steps of delay
    for (genvar c = 0; c < ARRAY_DIM - 1; c++) begin : g_deskew
        wssm_deskew #(
            .DEPTH (ARRAY_DIM - 1 - c)
        ) u_deskew (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_advance  (advance),
            .i_byte     (psum[ARRAY_DIM-1][c][ELEM_BITS-1:0]),
            .o_tap_next (tap_next[c])
        );
    end

    assign tap_next[ARRAY_DIM-1] = advance ? psum_nx[ARRAY_DIM-1][ARRAY_DIM-1][ELEM_BITS-1:0]
                                           : psum[ARRAY_DIM-1][ARRAY_DIM-1][ELEM_BITS-1:0];

    always_comb begin
        read_word = '0;
        for (int i = 0; i < ELEMS_PER_WORD; i++) begin
            for (int c = 0; c < ARRAY_DIM; c++) begin
                if (mod_hit(int'(idx) + ELEMS_PER_WORD + i, c)) begin
                    read_word[WORD_BITS-1-ELEM_BITS*i -: ELEM_BITS] =
                        read_word[WORD_BITS-1-ELEM_BITS*i -: ELEM_BITS] | tap_next[c];
                end
            end
        end

        n_flag = r_flag;
        n_word = '0;
        unique case (kind)
            KIND_LOAD_WEIGHTS: begin
                n_flag = r_flag | (word != '0);
            end
            KIND_STREAM: begin
                n_flag = 1'b0;
                n_word = read_word;
            end
            KIND_STORE: begin
                n_word = read_word;
            end
            KIND_NOP: begin
                n_word = '0;
            end
            default: begin
                n_word = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_flag      <= n_flag;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_word <= n_word;
            r_out_flag <= n_flag;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_DATA_BITS - WORD_BITS - 1)'(0), r_out_flag, r_out_word};

endmodule

// ===== hw/rtl/wssm_pe.sv =====
// ----------------------------------------------------------------------------
// wssm_pe
// Processing element: stationary weight, activation hand-off to the right,
// signed multiply-add into the partial sum handed down.
// ----------------------------------------------------------------------------
module wssm_pe #(
    parameter int ACC_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wssm_pkg::t_pe_ctrl    i_ctrl,
    input  wssm_pkg::t_elem       i_act,
    input  logic [ACC_BITS-1:0]   i_psum,
    output wssm_pkg::t_elem       o_act,
    output logic [ACC_BITS-1:0]   o_psum,
    output logic [ACC_BITS-1:0]   o_psum_next
);
    import wssm_pkg::*;

    t_elem               r_w;
    t_elem               r_act;
    logic [ACC_BITS-1:0] r_psum;
    logic signed [2*ELEM_BITS-1:0] prod;
    logic [ACC_BITS-1:0] n_psum;

    always_comb begin
        prod   = (2*ELEM_BITS)'($signed(i_act)) * (2*ELEM_BITS)'($signed(r_w));
        n_psum = i_psum + ACC_BITS'($signed(prod));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= '0;
            r_act  <= '0;
            r_psum <= '0;
        end else begin
            if (i_ctrl.w_we) begin
                r_w <= i_ctrl.w_data;
            end
            if (i_ctrl.advance) begin
                r_act  <= i_act;
                r_psum <= n_psum;
            end
        end
    end

    assign o_act       = r_act;
    assign o_psum      = r_psum;
    assign o_psum_next = n_psum;

endmodule

// ===== hw/rtl/wssm_skew_row.sv =====
// ----------------------------------------------------------------------------
// wssm_skew_row
// One row of the input skew buffer: single write position, shift right on
// advance with the first column held, tap at the last column.
// ----------------------------------------------------------------------------
module wssm_skew_row #(
    parameter int ARRAY_DIM = 8,
    parameter int WR_COL    = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_we,
    input  wssm_pkg::t_elem i_data,
    input  logic            i_advance,
    output wssm_pkg::t_elem o_tap
);
    import wssm_pkg::*;

    t_elem r_row [ARRAY_DIM];
    t_elem merged [ARRAY_DIM];
    t_elem n_row [ARRAY_DIM];

    always_comb begin
        for (int c = 0; c < ARRAY_DIM; c++) begin
            merged[c] = (i_we && c == WR_COL) ? i_data : r_row[c];
        end
        n_row[0] = merged[0];
        for (int c = 1; c < ARRAY_DIM; c++) begin
            n_row[c] = i_advance ? merged[c-1] : merged[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < ARRAY_DIM; c++) begin
                r_row[c] <= '0;
            end
        end else begin
            for (int c = 0; c < ARRAY_DIM; c++) begin
                r_row[c] <= n_row[c];
            end
        end
    end

    assign o_tap = merged[ARRAY_DIM-1];

endmodule

// ===== hw/rtl/wssm_deskew.sv =====
// ----------------------------------------------------------------------------
// wssm_deskew
// Output de-skew delay line for one column: shifts the bottom sum byte in on
// advance and presents the value the far stage takes this cycle.
// ----------------------------------------------------------------------------
module wssm_deskew #(
    parameter int DEPTH = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_advance,
    input  wssm_pkg::t_elem i_byte,
    output wssm_pkg::t_elem o_tap_next
);
    import wssm_pkg::*;

    t_elem r_stage [DEPTH];
    t_elem n_stage [DEPTH];

    always_comb begin
        n_stage[0] = i_advance ? i_byte : r_stage[0];
        for (int k = 1; k < DEPTH; k++) begin
            n_stage[k] = i_advance ? r_stage[k-1] : r_stage[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_stage[k] <= '0;
            end
        end else begin
            for (int k = 0; k < DEPTH; k++) begin
                r_stage[k] <= n_stage[k];
            end
        end
    end

    assign o_tap_next = n_stage[DEPTH-1];

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stream testbench for the weight-stationary systolic array. Weight loads,
// streaming steps and non-advancing reads go in through the slave port, with
// bursty sending and a stalling receiver. An internal array predictor keeps
// its own grids and tile flag and checks every result beat in order.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import wssm_pkg::*;

    localparam int DIM        = 8;
    localparam int CELLS      = DIM * DIM;
    localparam int DRAIN_WAIT = 16;

    typedef struct {
        t_kind       kind;
        logic [5:0]  idx;
        logic [31:0] sum_bytes;
        logic        tile_nz;
    } t_array_out;

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    // [5:0] index, [37:6] bus_word, [39:38] zero
    logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
    // [1:0] kind
    logic [KIND_BITS-1:0]     s_axis_tuser  = KIND_LOAD_WEIGHTS;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // [31:0] result_word, [32] nonzero_tile, [39:33] zero
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;

    weight_stationary_systolic_matmul_top #(
        .ARRAY_DIM (DIM),
        .ACC_BITS  (32)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // predictor state
    logic [7:0]  weight_q   [CELLS];
    logic [7:0]  skew_in_q  [CELLS];
    logic [7:0]  act_q      [CELLS];
    logic [31:0] psum_q     [CELLS + DIM];
    logic [7:0]  deskew_q   [CELLS];
    logic        tile_nz_q;

    t_array_out  awaited_outputs [$];
    int          mismatches  = 0;
    int          beats_in    [3];
    int          beats_out   = 0;
    int          burst_left  = 0;
    bit          steady      = 1'b0;

    function automatic logic [7:0] elem_of(logic [31:0] word, int n);
        return word[8 * (ELEMS_PER_WORD - 1 - n) +: 8];
    endfunction

    task automatic place_acts(logic [5:0] idx, logic [31:0] word);
        int r;
        for (int i = 0; i < ELEMS_PER_WORD; i++) begin
            r = (idx + i) % DIM;
            skew_in_q[r * DIM + DIM - 1 - r] = elem_of(word, i);
        end
    endtask

    task automatic advance_grid();
        logic signed [7:0] sa, sw;
        int                prod;
        for (int i = 0; i < DIM; i++) begin
            act_q[i * DIM] = skew_in_q[i * DIM + DIM - 1];
            for (int j = DIM - 1; j > 0; j--)
                skew_in_q[i * DIM + j] = skew_in_q[i * DIM + j - 1];
        end
        for (int i = CELLS - 1; i >= 0; i--) begin
            sa = act_q[i];
            sw = weight_q[i];
            prod = int'(sa) * int'(sw);
            psum_q[i + DIM] = prod + psum_q[i];
        end
        for (int i = 0; i < DIM; i++)
            for (int j = DIM - 1; j > 0; j--)
                act_q[i * DIM + j] = act_q[i * DIM + j - 1];
        for (int j = 0; j < DIM; j++) begin
            for (int i = DIM - 1; i > 0; i--)
                deskew_q[i * DIM + j] = deskew_q[(i - 1) * DIM + j];
            deskew_q[j] = psum_q[CELLS + j][7:0];
        end
    endtask

    function automatic logic [31:0] read_bytes(logic [5:0] idx);
        logic [31:0] res;
        int          b, col;
        res = '0;
        b = (idx + ELEMS_PER_WORD) % DIM;
        for (int i = 0; i < ELEMS_PER_WORD; i++) begin
            col = (b + i) % DIM;
            res[8 * (ELEMS_PER_WORD - 1 - i) +: 8] = deskew_q[(DIM - 1 - col) * DIM + col];
        end
        return res;
    endfunction

    task automatic array_predict(t_kind kind, logic [5:0] idx, logic [31:0] word,
                                 output t_array_out pred);
        pred.kind = kind;
        pred.idx = idx;
        pred.sum_bytes = '0;
        case (kind)
            KIND_LOAD_WEIGHTS: begin
                for (int i = 0; i < ELEMS_PER_WORD; i++)
                    if (idx + i < CELLS)
                        weight_q[idx + i] = elem_of(word, i);
                if (word != 0)
                    tile_nz_q = 1'b1;
            end
            KIND_STREAM: begin
                tile_nz_q = 1'b0;
                place_acts(idx, word);
                advance_grid();
                pred.sum_bytes = read_bytes(idx);
            end
            KIND_STORE: begin
                place_acts(idx, word);
                pred.sum_bytes = read_bytes(idx);
            end
            default: ;
        endcase
        pred.tile_nz = tile_nz_q;
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_array_out exp_out;
        t_array_out pred;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                weight_q[i] = '0;
                skew_in_q[i] = '0;
                act_q[i] = '0;
                deskew_q[i] = '0;
            end
            for (int i = 0; i < CELLS + DIM; i++)
                psum_q[i] = '0;
            tile_nz_q = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                beats_out++;
                if (awaited_outputs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result beat %h", $time, m_axis_tdata);
                end else begin
                    exp_out = awaited_outputs.pop_front();
                    if (m_axis_tdata[31:0] !== exp_out.sum_bytes ||
                        m_axis_tdata[32] !== exp_out.tile_nz) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: %s idx %0d: expected result %h flag %b, got %h flag %b",
                                     $time, exp_out.kind.name(), exp_out.idx,
                                     exp_out.sum_bytes, exp_out.tile_nz,
                                     m_axis_tdata[31:0], m_axis_tdata[32]);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                array_predict(t_kind'(s_axis_tuser), s_axis_tdata[5:0],
                              s_axis_tdata[37:6], pred);
                awaited_outputs.push_back(pred);
                if (s_axis_tuser < 3)
                    beats_in[s_axis_tuser]++;
            end
        end
    end

    // receiver stall pattern, reshuffled whenever the low six bits of rx_cycle are zero
    logic [31:0] stall_pat = '1;
    logic [15:0] rx_cycle  = '0;

    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1'b1;
        if (rx_cycle[5:0] == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pat <= '1;
                1: stall_pat <= $urandom;
                2: stall_pat <= $urandom & $urandom;
                default: stall_pat <= $urandom | $urandom;
            endcase
        end
        m_axis_tready <= stall_pat[rx_cycle[4:0]];
    end

    task automatic send_beat(t_kind kind, logic [5:0] idx, logic [31:0] word);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {2'b00, word, idx};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic logic [31:0] edgy_word();
        logic [31:0] w;
        for (int i = 0; i < 4; i++) begin
            case ($urandom_range(0, 7))
                0: w[8 * i +: 8] = 8'h80;
                1: w[8 * i +: 8] = 8'h7F;
                2: w[8 * i +: 8] = 8'hFF;
                3: w[8 * i +: 8] = 8'h00;
                default: w[8 * i +: 8] = 8'($urandom_range(0, 255));
            endcase
        end
        return w;
    endfunction

    task automatic test_weight_load();
        send_beat(KIND_LOAD_WEIGHTS, 6'd0,  32'h0102_0304);
        send_beat(KIND_LOAD_WEIGHTS, 6'd4,  32'h8080_8080);
        send_beat(KIND_LOAD_WEIGHTS, 6'd60, 32'h80FF_7F01);
        send_beat(KIND_LOAD_WEIGHTS, 6'd61, 32'hFFFF_FFFF);
        send_beat(KIND_LOAD_WEIGHTS, 6'd63, 32'h7F00_0000);
        send_beat(KIND_LOAD_WEIGHTS, 6'd62, 32'h0000_0000);
    endtask

    task automatic test_tile_flag();
        send_beat(KIND_STREAM,       6'd0,  32'h0000_0000);
        send_beat(KIND_LOAD_WEIGHTS, 6'd8,  32'h0000_0000);
        send_beat(KIND_STORE,        6'd3,  32'h1122_3344);
        send_beat(KIND_LOAD_WEIGHTS, 6'd8,  32'h0000_0100);
        send_beat(KIND_STORE,        6'd63, 32'hFFFF_FFFF);
    endtask

    task automatic test_stream_extremes();
        send_beat(KIND_STREAM, 6'd0,  32'h8080_8080);
        send_beat(KIND_STREAM, 6'd4,  32'h7F7F_7F7F);
        send_beat(KIND_STREAM, 6'd7,  32'hFFFF_FFFF);
        send_beat(KIND_STREAM, 6'd63, 32'h0000_0000);
        for (int k = 0; k < 6; k++)
            send_beat(KIND_STREAM, 6'(k * 4), 32'h8080_8080);
        send_beat(KIND_STORE,  6'd5,  32'h807F_FF01);
        send_beat(KIND_STORE,  6'd58, 32'h0000_0000);
    endtask

    // full weight tile (now and then a single weight word) then a run of activation beats, with some reads mixed in
    task automatic test_random_tiles(int n_items);
        int sent, run_len, base;
        sent = 0;
        while (sent < n_items) begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 4) != 0) begin
                for (int k = 0; k < CELLS / 4; k++)
                    send_beat(KIND_LOAD_WEIGHTS, 6'(k * 4),
                              ($urandom_range(0, 9) == 0) ? 32'h0 : edgy_word());
                sent += CELLS / 4;
            end else begin
                send_beat(KIND_LOAD_WEIGHTS, 6'($urandom_range(0, 63)), edgy_word());
                sent++;
            end
            run_len = $urandom_range(8, 40);
            base = $urandom_range(0, 63);
            for (int k = 0; k < run_len; k++) begin
                send_beat(($urandom_range(0, 6) == 0) ? KIND_STORE : KIND_STREAM,
                          ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                      : 6'(base + 4 * k),
                          edgy_word());
            end
            sent += run_len;
        end
        steady = 1'b0;
    endtask

    task automatic test_random_noise(int n_items);
        for (int k = 0; k < n_items; k++)
            send_beat(t_kind'($urandom_range(0, 2)), 6'($urandom_range(0, 63)), $urandom);
    endtask

    initial begin
        int waited;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_weight_load();
        test_tile_flag();
        test_stream_extremes();
        test_random_tiles(1300);
        test_random_noise(350);

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (awaited_outputs.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (awaited_outputs.size() != 0) begin
            mismatches += awaited_outputs.size();
            $display("%0d result beats never arrived", awaited_outputs.size());
        end

        $display("Covered %0d weight loads, %0d array steps, %0d plain reads; %0d results checked.",
                 beats_in[0], beats_in[1], beats_in[2], beats_out);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Timeout waiting for the array to drain");
        $display("TEST FAILED");
        $finish;
    end

endmodule
